/* design/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg: shared types and microprogram for the second-chance replacer
// Holds the item structs, the control word format, the step addresses and the
// read-only microprogram that drives the replacer datapath.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int PAGE_W  = 20;
	localparam int FRAME_W = 3;
	localparam int COUNT_W = 16;
	localparam int CFG_W   = 4;
	localparam int UPC_W   = 4;

	// Request item fields.
	typedef struct packed {
		logic [PAGE_W-1:0] vpage;
		logic              dirty;
	} esc_in_t;

	// Result item fields.
	typedef struct packed {
		logic               fault;
		logic [FRAME_W-1:0] frame;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
		logic               evicted_dirty;
		logic [COUNT_W-1:0] fault_count;
	} esc_out_t;

	// Microprogram step addresses.
	typedef enum logic [UPC_W-1:0] {
		U_IDLE  = 4'd0,
		U_HCHK  = 4'd1,
		U_HCMP  = 4'd2,
		U_HIT   = 4'd3,
		U_MISS  = 4'd4,
		U_FILL  = 4'd5,
		U_V00   = 4'd6,
		U_V01   = 4'd7,
		U_VRD   = 4'd8,
		U_VOUT  = 4'd9
	} upc_t;

	// Branch conditions tested by a step.
	typedef enum logic [2:0] {
		C_ALWAYS  = 3'd0,
		C_START   = 3'd1,
		C_HIT_END = 3'd2,
		C_MATCH   = 3'd3,
		C_ROOM    = 3'd4,
		C_CLS00   = 3'd5,
		C_CLS01   = 3'd6
	} cond_t;

	// Frame index counter operations.
	typedef enum logic [2:0] {
		I_HOLD = 3'd0,
		I_CLR  = 3'd1,
		I_INC  = 3'd2,
		I_FILL = 3'd3,
		I_WRAP = 3'd4
	} idx_op_t;

	// Datapath actions on the frame tables.
	typedef enum logic [2:0] {
		A_NONE   = 3'd0,
		A_HIT    = 3'd1,
		A_FILL   = 3'd2,
		A_EVICT  = 3'd3,
		A_CLRREF = 3'd4
	} act_t;

	// One control word: a taken and a not-taken half, plus a wrap target
	// used when the counter wraps on the not-taken path.
	typedef struct packed {
		cond_t   cond;
		upc_t    jt;
		upc_t    jf;
		upc_t    jw;
		idx_op_t idx_t;
		idx_op_t idx_f;
		act_t    act_t_op;
		act_t    act_f_op;
		logic    rd;
	} uword_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic hit_end;
		logic match;
		logic room;
		logic cls00;
		logic cls01;
		logic last;
	} esc_flags_t;

	// Resolved control from the sequencer to the datapath.
	typedef struct packed {
		logic    accept;
		idx_op_t idx_op;
		act_t    act;
		logic    rd;
	} esc_ctrl_t;

	// The microprogram.
	function automatic uword_t ucode(input upc_t a);
		uword_t w;
		w = '{cond: C_ALWAYS, jt: U_IDLE, jf: U_IDLE, jw: U_IDLE,
		      idx_t: I_HOLD, idx_f: I_HOLD, act_t_op: A_NONE, act_f_op: A_NONE,
		      rd: 1'b0};
		unique case (a)
			U_IDLE: begin
				w.cond = C_START;  w.jt = U_HCHK; w.jf = U_IDLE; w.jw = U_IDLE;
				w.idx_t = I_CLR;
			end
			U_HCHK: begin
				w.cond = C_HIT_END; w.jt = U_MISS; w.jf = U_HCMP; w.jw = U_HCMP;
				w.rd = 1'b1;
			end
			U_HCMP: begin
				w.cond = C_MATCH;  w.jt = U_HIT;  w.jf = U_HCHK; w.jw = U_HCHK;
				w.idx_f = I_INC;
			end
			U_HIT: begin
				w.cond = C_ALWAYS; w.jt = U_IDLE;
				w.act_t_op = A_HIT;
			end
			U_MISS: begin
				w.cond = C_ROOM;   w.jt = U_FILL; w.jf = U_V00;  w.jw = U_V00;
				w.idx_t = I_FILL;  w.idx_f = I_CLR;
			end
			U_FILL: begin
				w.cond = C_ALWAYS; w.jt = U_IDLE;
				w.act_t_op = A_FILL;
			end
			U_V00: begin
				w.cond = C_CLS00;  w.jt = U_VRD;  w.jf = U_V00;  w.jw = U_V01;
				w.idx_f = I_WRAP;
			end
			U_V01: begin
				w.cond = C_CLS01;  w.jt = U_VRD;  w.jf = U_V01;  w.jw = U_V00;
				w.idx_f = I_WRAP;  w.act_f_op = A_CLRREF;
			end
			U_VRD: begin
				w.cond = C_ALWAYS; w.jt = U_VOUT;
				w.rd = 1'b1;
			end
			U_VOUT: begin
				w.cond = C_ALWAYS; w.jt = U_IDLE;
				w.act_t_op = A_EVICT;
			end
			default: begin
				w.cond = C_ALWAYS; w.jt = U_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

/* design/enhanced_second_chance_replacer.sv */
// ----------------------------------------------------------------------------
// enhanced_second_chance_replacer: microcoded page replacement unit
// Looks up a page reference among the managed frames and, on a fault, fills a
// free frame or picks a victim by the enhanced second-chance classes.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                 Handshake
//  request   start, busy, request    taken when start is high and busy is low
//  result    done, result            shown for one cycle, cannot be held off
//  config    cfg_we, cfg_wdata       written on any edge with cfg_we high
//
// One item is in flight at a time. A hit steps through the HCHK and HCMP
// steps for each frame up to the match, around the registered page read; a
// fill or eviction first scans every resident frame. Victim scans take one
// frame per cycle. The receiver cannot stall. Reset clears the frame bits,
// the index, fill and fault counters and sets the frame count to 8; page
// memory is not cleared.
module enhanced_second_chance_replacer #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  esc_pkg::esc_in_t          request,
	output logic                      done,
	output esc_pkg::esc_out_t         result,
	input  logic                      cfg_we,
	input  logic [esc_pkg::CFG_W-1:0] cfg_wdata
);
	import esc_pkg::*;

	esc_flags_t flags;
	esc_ctrl_t  ctrl;

	// Microprogram sequencer.
	esc_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Frame tables and counters.
	esc_dp #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.request   (request),
		.flags     (flags),
		.done      (done),
		.result    (result)
	);

endmodule

/* design/esc_useq.sv */
// ----------------------------------------------------------------------------
// esc_useq: microprogram sequencer
// Step counter, control word fetch and conditional next-step selection.
// ----------------------------------------------------------------------------
module esc_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  esc_pkg::esc_flags_t flags,
	output esc_pkg::esc_ctrl_t  ctrl,
	output logic               busy
);
	import esc_pkg::*;

	upc_t   upc_q;
	upc_t   upc_next;
	uword_t uw;
	logic   idle;
	logic   taken;

	assign uw   = ucode(upc_q);
	assign idle = (upc_q == U_IDLE);
	assign busy = !idle;

	// Evaluate the branch condition of the current step.
	always_comb begin
		unique case (uw.cond)
			C_ALWAYS:  taken = 1'b1;
			C_START:   taken = start && idle;
			C_HIT_END: taken = flags.hit_end;
			C_MATCH:   taken = flags.match;
			C_ROOM:    taken = flags.room;
			C_CLS00:   taken = flags.cls00;
			C_CLS01:   taken = flags.cls01;
			default:   taken = 1'b0;
		endcase
	end

	// Resolve the datapath controls for the chosen branch.
	always_comb begin
		ctrl.accept = start && idle;
		ctrl.idx_op = taken ? uw.idx_t : uw.idx_f;
		ctrl.act    = taken ? uw.act_t_op : uw.act_f_op;
		ctrl.rd     = uw.rd;
	end

	// Next step: taken target, wrap target when the scan wraps, else fall.
	always_comb begin
		priority if (taken) begin
			upc_next = uw.jt;
		end else if (uw.idx_f == I_WRAP && flags.last) begin
			upc_next = uw.jw;
		end else begin
			upc_next = uw.jf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

/* design/esc_dp.sv */
// ----------------------------------------------------------------------------
// esc_dp: replacer datapath
// Frame page memory, reference and modify bits, frame index counter, fill and
// fault counters, and the result register.
// ----------------------------------------------------------------------------
module esc_dp #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  esc_pkg::esc_ctrl_t        ctrl,
	input  logic                      cfg_we,
	input  logic [esc_pkg::CFG_W-1:0] cfg_wdata,
	input  esc_pkg::esc_in_t          request,
	output esc_pkg::esc_flags_t       flags,
	output logic                      done,
	output esc_pkg::esc_out_t         result
);
	import esc_pkg::*;

	localparam int IW = $clog2(FRAMES);
	localparam int CW = $clog2(FRAMES + 1);

	logic [PAGE_BITS-1:0] page_mem [FRAMES];
	logic [PAGE_BITS-1:0] rdata_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 dirty_q;
	logic [FRAMES-1:0]    ref_q;
	logic [FRAMES-1:0]    mod_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        filled_q;
	logic [CFG_W-1:0]     frames_q;
	logic [COUNT_W-1:0]   fcnt_q;
	logic [COUNT_W-1:0]   fcnt_inc;
	logic                 done_q;
	esc_out_t             result_q;
	logic [IW-1:0]        ix;
	logic [CW-1:0]        n;
	logic [CW-1:0]        resident;
	logic                 wr;

	assign ix       = idx_q[IW-1:0];
	assign wr       = (ctrl.act == A_FILL) || (ctrl.act == A_EVICT);
	assign fcnt_inc = (&fcnt_q) ? fcnt_q : fcnt_q + COUNT_W'(1);

	// Effective frame count: zero acts as one, large values clamp to FRAMES.
	always_comb begin
		priority if (frames_q == '0) begin
			n = CW'(1);
		end else if (32'(frames_q) > FRAMES) begin
			n = CW'(FRAMES);
		end else begin
			n = CW'(frames_q);
		end
	end

	assign resident = (filled_q < n) ? filled_q : n;

	// Status for the sequencer.
	always_comb begin
		flags.hit_end = (idx_q == resident);
		flags.match   = (rdata_q == page_q);
		flags.room    = (filled_q < n);
		flags.cls00   = !ref_q[ix] && !mod_q[ix];
		flags.cls01   = !ref_q[ix] && mod_q[ix];
		flags.last    = (idx_q == n - CW'(1));
	end

	// Frame page memory with registered read.
	always_ff @(posedge clk) begin
		if (wr) begin
			page_mem[ix] <= page_q;
		end
		if (ctrl.rd) begin
			rdata_q <= page_mem[ix];
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			page_q  <= PAGE_BITS'(request.vpage);
			dirty_q <= request.dirty;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= CFG_W'(8);
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	// Frame index counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			unique case (ctrl.idx_op)
				I_HOLD:  idx_q <= idx_q;
				I_CLR:   idx_q <= '0;
				I_INC:   idx_q <= idx_q + CW'(1);
				I_FILL:  idx_q <= filled_q;
				I_WRAP:  idx_q <= flags.last ? '0 : idx_q + CW'(1);
				default: idx_q <= idx_q;
			endcase
		end
	end

	// Reference and modify bits, fill and fault counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q    <= '0;
			mod_q    <= '0;
			filled_q <= '0;
			fcnt_q   <= '0;
		end else begin
			unique case (ctrl.act)
				A_HIT: begin
					ref_q[ix] <= 1'b1;
					mod_q[ix] <= mod_q[ix] | dirty_q;
				end
				A_FILL: begin
					ref_q[ix] <= 1'b1;
					mod_q[ix] <= dirty_q;
					filled_q  <= filled_q + CW'(1);
					fcnt_q    <= fcnt_inc;
				end
				A_EVICT: begin
					ref_q[ix] <= 1'b1;
					mod_q[ix] <= dirty_q;
					fcnt_q    <= fcnt_inc;
				end
				A_CLRREF: begin
					ref_q[ix] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.act == A_HIT) || wr;
		end
	end

	// Result item register.
	always_ff @(posedge clk) begin
		if (ctrl.act == A_HIT || wr) begin
			result_q.fault         <= wr;
			result_q.frame         <= FRAME_W'(idx_q);
			result_q.evicted_valid <= (ctrl.act == A_EVICT);
			result_q.evicted_page  <= (ctrl.act == A_EVICT) ? PAGE_W'(rdata_q) : '0;
			result_q.evicted_dirty <= (ctrl.act == A_EVICT) && mod_q[ix];
			result_q.fault_count   <= wr ? fcnt_inc : fcnt_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* design/esc_checker.sv */
// ----------------------------------------------------------------------------
// esc_checker: port-level checks for the replacer
// Concurrent assertions on the request, result and busy ports over time.
// ----------------------------------------------------------------------------
module esc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input esc_pkg::esc_out_t result,
	input logic              cfg_we
);
	import esc_pkg::*;

	// An accepted item keeps the unit busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the unit busy");

	// A result ends the item's work: the unit is free while it is shown.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result shown while busy or without prior work");

	// Only a fault can evict a page.
	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.evicted_valid |-> result.fault)
		else $error("eviction reported without a fault");

	// Without an eviction the evicted fields are zero.
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.evicted_valid |->
			result.evicted_page == '0 && !result.evicted_dirty)
		else $error("evicted fields set without an eviction");

	// The frame count is only written while no item is in flight.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !busy)
		else $error("frame count written while an item is in flight");

endmodule

bind enhanced_second_chance_replacer esc_checker u_esc_checker (.*);

/* tb/sv/tb_enhanced_second_chance_replacer.sv */
// ----------------------------------------------------------------------------
// tb_enhanced_second_chance_replacer: self-checking bench for the replacer
// Sends page references through the start/busy port and compares every done
// strobe, field by field, with a page-table shadow kept inside the bench. It
// covers fills, hits, both victim classes, frame count changes and a long
// stream of faults on a single frame.
// ----------------------------------------------------------------------------
module tb_enhanced_second_chance_replacer;
	timeunit 1ns;
	timeprecision 1ps;

	import esc_pkg::*;

	localparam int          FRAMES       = 8;
	localparam int          PAGE_BITS    = 20;
	localparam logic [15:0] FAULT_MAX    = 16'hFFFF;
	localparam logic [1:0]  CLS_00       = 2'b00;
	localparam logic [1:0]  CLS_01       = 2'b01;
	localparam int          DRAIN_CYCLES = 2 * FRAMES + 3 * FRAMES + 8;
	localparam int          LIMIT_CYCLES = 300_000;
	localparam int          RAND_PHASES  = 6;
	localparam int          PHASE_ITEMS  = 140;
	localparam int          STREAM_ITEMS = 32;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic                busy;
	esc_in_t             request   = '0;
	logic                done;
	esc_out_t            result;
	logic                cfg_we    = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;

	// Shadow of the frame tables and the frame count register.
	logic [PAGE_BITS-1:0] shadow_page [FRAMES];
	bit                   ref_bits    [FRAMES];
	bit                   mod_bits    [FRAMES];
	int unsigned          filled;
	logic [15:0]          fault_total;
	logic [CFG_W-1:0]     frame_count_reg;

	esc_out_t pending_results[$];
	esc_out_t oldest;
	int       fail_count     = 0;
	int       items_accepted = 0;
	int       hits_seen      = 0;
	int       evictions_seen = 0;
	int       cycle_count    = 0;

	enhanced_second_chance_replacer #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Works out the result of one page reference and updates the shadow tables.
	function automatic esc_out_t predict_reference(input esc_in_t item);
		esc_out_t    r;
		int unsigned n;
		int unsigned resident;
		int unsigned slot;
		int unsigned i;
		int          rnd;
		bit          found;
		r        = '0;
		r.fault  = 1'b1;
		slot     = 0;
		n        = (frame_count_reg == 0) ? 1 :
		           ((frame_count_reg > FRAMES) ? FRAMES : frame_count_reg);
		resident = (filled < n) ? filled : n;

		// Hit search over the resident managed frames.
		for (i = 0; i < resident && r.fault; i++) begin
			if (shadow_page[i] == item.vpage) begin
				ref_bits[i] = 1'b1;
				mod_bits[i] = mod_bits[i] | item.dirty;
				slot        = i;
				r.fault     = 1'b0;
			end
		end

		if (r.fault) begin
			if (filled < n) begin
				slot   = filled;
				filled = filled + 1;
			end else begin
				// Class 00 first, then class 01 while clearing reference bits.
				found = 1'b0;
				for (rnd = 0; rnd < 2 && !found; rnd++) begin
					for (i = 0; i < n && !found; i++) begin
						if ({ref_bits[i], mod_bits[i]} == CLS_00) begin
							slot  = i;
							found = 1'b1;
						end
					end
					for (i = 0; i < n && !found; i++) begin
						if ({ref_bits[i], mod_bits[i]} == CLS_01) begin
							slot  = i;
							found = 1'b1;
						end else begin
							ref_bits[i] = 1'b0;
						end
					end
				end
				r.evicted_valid = 1'b1;
				r.evicted_page  = shadow_page[slot];
				r.evicted_dirty = mod_bits[slot];
				evictions_seen++;
			end
			shadow_page[slot] = item.vpage;
			ref_bits[slot]    = 1'b1;
			mod_bits[slot]    = item.dirty;
			if (fault_total != FAULT_MAX)
				fault_total = fault_total + 1'b1;
		end else begin
			hits_seen++;
		end
		r.frame       = slot[FRAME_W-1:0];
		r.fault_count = fault_total;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Compares each done strobe with the oldest prediction, then records
	// register writes and accepted items. All signals are sampled as they
	// stood before the edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FRAMES; k++) begin
				shadow_page[k] = '0;
				ref_bits[k]    = 1'b0;
				mod_bits[k]    = 1'b0;
			end
			filled          = 0;
			fault_total     = '0;
			frame_count_reg = CFG_W'(FRAMES);
			pending_results.delete();
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result item arrived with no prediction waiting");
					fail_count++;
				end else begin
					oldest = pending_results.pop_front();
					check_field("fault", oldest.fault, result.fault);
					check_field("frame", oldest.frame, result.frame);
					check_field("evicted_valid", oldest.evicted_valid,
					            result.evicted_valid);
					check_field("evicted_page", oldest.evicted_page,
					            result.evicted_page);
					check_field("evicted_dirty", oldest.evicted_dirty,
					            result.evicted_dirty);
					check_field("fault_count", oldest.fault_count,
					            result.fault_count);
				end
			end
			if (cfg_we)
				frame_count_reg = cfg_wdata;
			if (start && !busy) begin
				pending_results.push_back(predict_reference(request));
				items_accepted++;
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one page reference and returns at the edge that takes it.
	task automatic send_reference(input logic [PAGE_BITS-1:0] page,
	                              input logic dirty, input int idle_pct);
		esc_in_t item;
		item.vpage = page;
		item.dirty = dirty;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start   <= 1'b1;
		request <= item;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Lowers start and waits until every predicted result has come back.
	task automatic wait_all_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_frame_count(input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Fills a reduced frame set, then widens it so fresh frames fill first.
	// A zero count acts as one frame and a count above the maximum as eight.
	task automatic test_fill_and_grow();
		write_frame_count(4'd3);
		send_reference(20'h00010, 1'b0, 30);
		send_reference(20'h00020, 1'b1, 30);
		send_reference(20'h00030, 1'b0, 30);
		send_reference(20'h00010, 1'b1, 30);
		send_reference(20'h00040, 1'b0, 30);
		wait_all_results();
		write_frame_count(4'd0);
		send_reference(20'h00050, 1'b1, 30);
		send_reference(20'h00050, 1'b0, 30);
		wait_all_results();
		write_frame_count(4'd6);
		send_reference(20'h00060, 1'b0, 30);
		send_reference(20'h00070, 1'b1, 30);
		send_reference(20'h00020, 1'b0, 30);
		wait_all_results();
		write_frame_count(4'd15);
		send_reference(20'h00080, 1'b0, 30);
		send_reference(20'h00090, 1'b1, 30);
		send_reference(20'h000A0, 1'b0, 30);
		wait_all_results();
	endtask

	// Extreme page numbers, hits that set the modify bit, victim classes.
	task automatic test_edge_pages();
		write_frame_count(4'd8);
		send_reference(20'h00000, 1'b0, 0);
		send_reference(20'hFFFFF, 1'b1, 0);
		send_reference(20'hAAAAA, 1'b1, 0);
		send_reference(20'h55555, 1'b0, 0);
		send_reference(20'hFFFFF, 1'b0, 0);
		send_reference(20'h00000, 1'b1, 0);
		send_reference(20'h00001, 1'b0, 0);
		send_reference(20'h00002, 1'b0, 0);
		wait_all_results();
	endtask

	// Lowers the count after filling: higher frames sit unused but keep pages.
	task automatic test_shrink_after_fill();
		write_frame_count(4'd2);
		send_reference(20'h00090, 1'b1, 30);
		send_reference(20'h12345, 1'b0, 30);
		send_reference(20'h00090, 1'b0, 30);
		wait_all_results();
		write_frame_count(4'd9);
		send_reference(20'h000A0, 1'b1, 30);
		send_reference(20'h12345, 1'b1, 30);
		wait_all_results();
	endtask

	// Random references drawn mostly from a small page pool so that hits and
	// both victim classes are frequent, with fresh random pages mixed in.
	task automatic test_random_traffic();
		logic [CFG_W-1:0]     counts   [RAND_PHASES];
		logic [PAGE_BITS-1:0] pool     [16];
		logic [PAGE_BITS-1:0] page;
		int                   pool_size;
		int                   idle_pct;
		counts = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd3};
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			write_frame_count(counts[ph]);
			pool_size = FRAMES / 2 + $urandom_range(1, 8);
			for (int k = 0; k < 16; k++)
				pool[k] = PAGE_BITS'($urandom_range(0, 20'hFFFFF));
			// One phase runs with no sender gaps at all.
			idle_pct = (ph == 2) ? 0 : 32;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(99) < 85)
					page = pool[$urandom_range(0, pool_size - 1)];
				else
					page = PAGE_BITS'($urandom_range(0, 20'hFFFFF));
				send_reference(page, 1'($urandom_range(0, 1)), idle_pct);
				// Now and then the sender holds off until the block drains.
				if (ph == 4 && k % 16 == 15)
					wait_all_results();
			end
			wait_all_results();
		end
	endtask

	// One managed frame and always-new pages fault on every item, each one after
	// the first evicting the page that the item before it brought in.
	task automatic test_fault_stream();
		logic [PAGE_BITS-1:0] page;
		write_frame_count(4'd1);
		page = 20'h00000;
		for (int k = 0; k < STREAM_ITEMS; k++) begin
			page = page + PAGE_BITS'($urandom_range(1, 1000));
			send_reference(page, 1'($urandom_range(0, 1)), 0);
		end
		wait_all_results();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_and_grow();
		test_edge_pages();
		test_shrink_after_fill();
		test_random_traffic();
		test_fault_stream();

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d result items never arrived", pending_results.size());
			fail_count++;
		end

		$display("Sent %0d references: %0d hits, %0d evictions, frame counts 0 to 15.",
		         items_accepted, hits_seen, evictions_seen);
		$display("Fault counter ended at 0x%0h; %0d mismatches.", fault_total, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
